/* src/dsp_pkg.sv */
package dsp_pkg;

	// default coordinate width and the fixed widths after normalization
	localparam int COORD_WIDTH_DEF = 32;
	localparam int NORM_BITS       = 29;
	localparam int NUM_W           = 63;
	localparam int DEN_W           = 35;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOCAL_X       = 3'd0,
		REG_FOCAL_Y       = 3'd1,
		REG_CENTER_X      = 3'd2,
		REG_CENTER_Y      = 3'd3,
		REG_SPHERE_OFFSET = 3'd4,
		REG_BLEND_RATIO   = 3'd5
	} reg_idx_t;

	localparam logic [31:0] FOCAL_X_RST       = 32'd33554432;
	localparam logic [31:0] FOCAL_Y_RST       = 32'd33554432;
	localparam logic [31:0] CENTER_X_RST      = 32'd20971520;
	localparam logic [31:0] CENTER_Y_RST      = 32'd15728640;
	localparam logic [31:0] SPHERE_OFFSET_RST = 32'd0;
	localparam logic [30:0] BLEND_RATIO_RST   = 31'd536870912;
	localparam logic [30:0] Q30_ONE           = 31'd1073741824;

endpackage

/* src/dsp_point_if.sv */
interface dsp_point_if #(
	parameter int W = 32
) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] point_x;
	logic signed [W-1:0] point_y;
	logic signed [W-1:0] point_z;

	modport source(output valid, point_x, point_y, point_z, input ready);
	modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

/* src/dsp_pixel_if.sv */
interface dsp_pixel_if #(
	parameter int W = 32
) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] pixel_u;
	logic signed [W-1:0] pixel_v;
	logic                valid_res;

	modport source(output valid, pixel_u, pixel_v, valid_res, input ready);
	modport sink(input valid, pixel_u, pixel_v, valid_res, output ready);
endinterface

/* src/dsp_sqrt_cell.sv */
module dsp_sqrt_cell #(
	parameter int K  = 0,
	parameter int NW = 60,
	parameter int RW = 30,
	parameter type side_t = logic
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] in_rem,
	input  logic [RW-1:0] in_root,
	input  side_t         in_side,
	output logic          out_valid,
	output logic [NW-1:0] out_rem,
	output logic [RW-1:0] out_root,
	output side_t         out_side
);
	localparam int TW = NW + 2;

	logic [TW-1:0] trial;
	logic          take;
	logic [NW-1:0] rem_nx;
	logic [RW-1:0] root_nx;

	// (2r + 2^k) * 2^k against the remainder n - r^2
	always_comb begin
		trial   = (TW'(in_root) << (K + 1)) + (TW'(1) << (2 * K));
		take    = TW'(in_rem) >= trial;
		rem_nx  = take ? (in_rem - trial[NW-1:0]) : in_rem;
		root_nx = take ? (in_root | (RW'(1) << K)) : in_root;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rem  <= rem_nx;
			out_root <= root_nx;
			out_side <= in_side;
		end
	end
endmodule

/* src/dsp_isqrt.sv */
module dsp_isqrt import dsp_pkg::*; #(
	parameter int NW = 60,
	parameter type side_t = logic
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [NW-1:0]       radicand,
	input  side_t               in_side,
	output logic                out_valid,
	output logic [(NW+1)/2-1:0] root,
	output side_t               out_side
);
	localparam int RW = (NW + 1) / 2;

	logic          vld_c  [RW+1];
	logic [NW-1:0] rem_c  [RW+1];
	logic [RW-1:0] root_c [RW+1];
	side_t         side_c [RW+1];

	assign vld_c[0]  = in_valid;
	assign rem_c[0]  = radicand;
	assign root_c[0] = '0;
	assign side_c[0] = in_side;

	// one root bit per cell, top bit first
	for (genvar i = 0; i < RW; i++) begin : g_cell
		dsp_sqrt_cell #(
			.K(RW - 1 - i), .NW(NW), .RW(RW), .side_t(side_t)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(vld_c[i]), .in_rem(rem_c[i]), .in_root(root_c[i]),
			.in_side(side_c[i]),
			.out_valid(vld_c[i+1]), .out_rem(rem_c[i+1]), .out_root(root_c[i+1]),
			.out_side(side_c[i+1])
		);
	end

	assign out_valid = vld_c[RW];
	assign root      = root_c[RW];
	assign out_side  = side_c[RW];
endmodule

/* src/dsp_div_cell.sv */
module dsp_div_cell import dsp_pkg::*; #(
	parameter int K  = 0,
	parameter int QB = 34,
	parameter type side_t = logic
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] in_rem_u,
	input  logic [NUM_W-1:0] in_rem_v,
	input  logic [QB:0]      in_q_u,
	input  logic [QB:0]      in_q_v,
	input  logic [DEN_W-1:0] in_den,
	input  side_t            in_side,
	output logic             out_valid,
	output logic [NUM_W-1:0] out_rem_u,
	output logic [NUM_W-1:0] out_rem_v,
	output logic [QB:0]      out_q_u,
	output logic [QB:0]      out_q_v,
	output logic [DEN_W-1:0] out_den,
	output side_t            out_side
);
	localparam int TW = ((NUM_W > DEN_W + K) ? NUM_W : DEN_W + K) + 1;

	logic [TW-1:0]    trial;
	logic             take_u;
	logic             take_v;
	logic [NUM_W-1:0] rem_u_nx;
	logic [NUM_W-1:0] rem_v_nx;
	logic [QB:0]      q_u_nx;
	logic [QB:0]      q_v_nx;

	// both lanes share the divisor
	always_comb begin
		trial    = TW'(in_den) << K;
		take_u   = TW'(in_rem_u) >= trial;
		take_v   = TW'(in_rem_v) >= trial;
		rem_u_nx = take_u ? (in_rem_u - trial[NUM_W-1:0]) : in_rem_u;
		rem_v_nx = take_v ? (in_rem_v - trial[NUM_W-1:0]) : in_rem_v;
		q_u_nx   = take_u ? (in_q_u | ((QB+1)'(1) << K)) : in_q_u;
		q_v_nx   = take_v ? (in_q_v | ((QB+1)'(1) << K)) : in_q_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rem_u <= rem_u_nx;
			out_rem_v <= rem_v_nx;
			out_q_u   <= q_u_nx;
			out_q_v   <= q_v_nx;
			out_den   <= in_den;
			out_side  <= in_side;
		end
	end
endmodule

/* src/dsp_divide.sv */
module dsp_divide import dsp_pkg::*; #(
	parameter int QB = 34,
	parameter type side_t = logic
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num_u,
	input  logic [NUM_W-1:0] num_v,
	input  logic [DEN_W-1:0] den,
	input  side_t            in_side,
	output logic             out_valid,
	output logic [QB:0]      quo_u,
	output logic [QB:0]      quo_v,
	output side_t            out_side
);
	localparam int NC = QB + 1;

	logic             vld_c [NC+1];
	logic [NUM_W-1:0] ru_c  [NC+1];
	logic [NUM_W-1:0] rv_c  [NC+1];
	logic [QB:0]      qu_c  [NC+1];
	logic [QB:0]      qv_c  [NC+1];
	logic [DEN_W-1:0] den_c [NC+1];
	side_t            sd_c  [NC+1];

	assign vld_c[0] = in_valid;
	assign ru_c[0]  = num_u;
	assign rv_c[0]  = num_v;
	assign qu_c[0]  = '0;
	assign qv_c[0]  = '0;
	assign den_c[0] = den;
	assign sd_c[0]  = in_side;

	// top cell flags a quotient too large for QB bits
	for (genvar i = 0; i < NC; i++) begin : g_cell
		dsp_div_cell #(.K(QB - i), .QB(QB), .side_t(side_t)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(vld_c[i]), .in_rem_u(ru_c[i]), .in_rem_v(rv_c[i]),
			.in_q_u(qu_c[i]), .in_q_v(qv_c[i]), .in_den(den_c[i]), .in_side(sd_c[i]),
			.out_valid(vld_c[i+1]), .out_rem_u(ru_c[i+1]), .out_rem_v(rv_c[i+1]),
			.out_q_u(qu_c[i+1]), .out_q_v(qv_c[i+1]), .out_den(den_c[i+1]),
			.out_side(sd_c[i+1])
		);
	end

	assign out_valid = vld_c[NC];
	assign quo_u     = qu_c[NC];
	assign quo_v     = qv_c[NC];
	assign out_side  = sd_c[NC];
endmodule

/* src/double_sphere_project.sv */
// channel    dir  word
// point_in   in   point_x, point_y, point_z
// pixel_out  out  pixel_u, pixel_v, valid_res
// cfg        in   cfg_we, cfg_index, cfg_data (write only)
//
// one point per cycle sustained while the output is taken; the pipeline
// holds 15 stage registers, the two square-root chains (30 and 32 cells),
// the divider chain (max(COORD_WIDTH,32)+3 cells) and the output register.
// the whole pipeline advances when the output register is empty or taken.
// reset clears every valid bit and loads the register defaults.
module double_sphere_project import dsp_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dsp_point_if.sink             point_in,
	dsp_pixel_if.source           pixel_out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int W   = COORD_WIDTH;
	localparam int BLW = $clog2(W + 1);
	localparam int SW  = W + NORM_BITS;
	localparam int QB  = ((W > 32) ? W : 32) + 2;
	localparam int FW  = QB + 2;
	localparam logic signed [FW-1:0] SAT_HI = {{(FW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [FW-1:0] SAT_LO = {{(FW-W+1){1'b1}}, {(W-1){1'b0}}};

	typedef struct packed {
		logic        ok;
		logic        px_neg;
		logic        py_neg;
		logic [28:0] mx;
		logic [28:0] my;
	} trk_t;

	typedef struct packed {
		trk_t               t;
		logic signed [29:0] pz;
		logic [58:0]        sq_xy;
	} side1_t;

	typedef struct packed {
		trk_t               t;
		logic signed [34:0] zsp;
	} side2_t;

	typedef struct packed {
		logic ok;
		logic u_neg;
		logic v_neg;
	} side3_t;

	// configuration registers
	logic        [31:0] focal_x_q;
	logic        [31:0] focal_y_q;
	logic signed [31:0] center_x_q;
	logic signed [31:0] center_y_q;
	logic signed [31:0] sphere_offset_q;
	logic        [30:0] blend_ratio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q       <= FOCAL_X_RST;
			focal_y_q       <= FOCAL_Y_RST;
			center_x_q      <= CENTER_X_RST;
			center_y_q      <= CENTER_Y_RST;
			sphere_offset_q <= SPHERE_OFFSET_RST;
			blend_ratio_q   <= BLEND_RATIO_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FOCAL_X:       focal_x_q       <= cfg_data;
				REG_FOCAL_Y:       focal_y_q       <= cfg_data;
				REG_CENTER_X:      center_x_q      <= cfg_data;
				REG_CENTER_Y:      center_y_q      <= cfg_data;
				REG_SPHERE_OFFSET: sphere_offset_q <= cfg_data;
				REG_BLEND_RATIO:   blend_ratio_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	logic out_valid_q;
	logic adv;

	assign adv            = !out_valid_q || pixel_out.ready;
	assign point_in.ready = adv;

	// valid chain of the plain stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s11, v_s12, v_s13, v_s14, v_s15;
	logic sq1_valid, sq2_valid, div_valid;

	// s1: magnitudes and signs
	logic [W-1:0] mx_s1, my_s1, mz_s1;
	logic         nx_s1, ny_s1, nz_s1;
	// s2: largest magnitude length
	logic [W-1:0]   mx_s2, my_s2, mz_s2;
	logic           nx_s2, ny_s2, nz_s2;
	logic [BLW-1:0] bl_s2;
	// s3: normalized
	trk_t               t_s3;
	logic [28:0]        mz_s3;
	logic               nz_s3;
	// s4: squares
	trk_t               t_s4;
	logic signed [29:0] pz_s4;
	logic [57:0]        sqx_s4, sqy_s4, sqz_s4;
	// s5: sums
	side1_t             sd_s5;
	logic [59:0]        sum1_s5;

	logic [W-1:0]   m_max;
	logic [BLW-1:0] bl_nx;
	logic [SW-1:0]  wx, wy, wz;

	always_comb begin
		m_max = (mx_s1 > my_s1) ? mx_s1 : my_s1;
		m_max = (mz_s1 > m_max) ? mz_s1 : m_max;
		bl_nx = '0;
		for (int i = 0; i < W; i++) begin
			if (m_max[i]) bl_nx = BLW'(i + 1);
		end
	end

	// shift all three by the same count so the largest lands in [2^28, 2^29)
	always_comb begin
		if (bl_s2 > BLW'(NORM_BITS)) begin
			wx = SW'(mx_s2) >> (bl_s2 - BLW'(NORM_BITS));
			wy = SW'(my_s2) >> (bl_s2 - BLW'(NORM_BITS));
			wz = SW'(mz_s2) >> (bl_s2 - BLW'(NORM_BITS));
		end else begin
			wx = SW'(mx_s2) << (BLW'(NORM_BITS) - bl_s2);
			wy = SW'(my_s2) << (BLW'(NORM_BITS) - bl_s2);
			wz = SW'(mz_s2) << (BLW'(NORM_BITS) - bl_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s1 <= point_in.point_x[W-1];
			ny_s1 <= point_in.point_y[W-1];
			nz_s1 <= point_in.point_z[W-1];
			mx_s1 <= point_in.point_x[W-1] ? W'(-point_in.point_x) : point_in.point_x;
			my_s1 <= point_in.point_y[W-1] ? W'(-point_in.point_y) : point_in.point_y;
			mz_s1 <= point_in.point_z[W-1] ? W'(-point_in.point_z) : point_in.point_z;

			mx_s2 <= mx_s1;
			my_s2 <= my_s1;
			mz_s2 <= mz_s1;
			nx_s2 <= nx_s1;
			ny_s2 <= ny_s1;
			nz_s2 <= nz_s1;
			bl_s2 <= bl_nx;

			t_s3.ok     <= bl_s2 != '0;
			t_s3.px_neg <= nx_s2;
			t_s3.py_neg <= ny_s2;
			t_s3.mx     <= wx[28:0];
			t_s3.my     <= wy[28:0];
			mz_s3       <= wz[28:0];
			nz_s3       <= nz_s2;

			t_s4   <= t_s3;
			pz_s4  <= nz_s3 ? -$signed({1'b0, mz_s3}) : $signed({1'b0, mz_s3});
			sqx_s4 <= t_s3.mx * t_s3.mx;
			sqy_s4 <= t_s3.my * t_s3.my;
			sqz_s4 <= mz_s3 * mz_s3;

			sd_s5.t     <= t_s4;
			sd_s5.pz    <= pz_s4;
			sd_s5.sq_xy <= 59'(sqx_s4) + 59'(sqy_s4);
			sum1_s5     <= 60'(sqx_s4) + 60'(sqy_s4) + 60'(sqz_s4);
		end
	end

	logic [29:0] d1;
	side1_t      sd1;

	dsp_isqrt #(.NW(60), .side_t(side1_t)) u_sqrt1 (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s5), .radicand(sum1_s5), .in_side(sd_s5),
		.out_valid(sq1_valid), .root(d1), .out_side(sd1)
	);

	// s6..s10: offset sphere and second radicand
	side1_t             sd_s6, sd_s7;
	logic signed [62:0] prod_s6;
	logic [32:0]        rz_s7;
	logic               rneg_s7;
	trk_t               t_s8, t_s9;
	logic [58:0]        sqxy_s8, sqxy_s9;
	logic signed [34:0] zsp_s8, zsp_s9;
	logic [63:0]        zsq_s9;
	side2_t             sd_s10;
	logic [63:0]        sum2_s10;
	logic [61:0]        pm;
	logic [33:0]        zmag;

	always_comb begin
		pm   = prod_s6[62] ? 62'(-prod_s6) : prod_s6[61:0];
		zmag = zsp_s8[34] ? 34'(-zsp_s8) : zsp_s8[33:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s6   <= sd1;
			prod_s6 <= sphere_offset_q * $signed({1'b0, d1});

			sd_s7   <= sd_s6;
			rneg_s7 <= prod_s6[62];
			rz_s7   <= 33'((63'(pm) + 63'(1 << 29)) >> 30);

			t_s8    <= sd_s7.t;
			sqxy_s8 <= sd_s7.sq_xy;
			zsp_s8  <= (rneg_s7 ? -$signed({2'b00, rz_s7}) : $signed({2'b00, rz_s7}))
				+ 35'(sd_s7.pz);

			t_s9    <= t_s8;
			sqxy_s9 <= sqxy_s8;
			zsp_s9  <= zsp_s8;
			zsq_s9  <= 64'(zmag * zmag);

			sd_s10.t   <= t_s9;
			sd_s10.zsp <= zsp_s9;
			sum2_s10   <= 64'(sqxy_s9) + zsq_s9;
		end
	end

	logic [31:0] d2;
	side2_t      sd2;

	dsp_isqrt #(.NW(64), .side_t(side2_t)) u_sqrt2 (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s10), .radicand(sum2_s10), .in_side(sd_s10),
		.out_valid(sq2_valid), .root(d2), .out_side(sd2)
	);

	// s11..s15: blend, round, numerators
	logic [30:0]        alpha;
	trk_t               t_s11, t_s12, t_s13, t_s14;
	logic [62:0]        p1_s11;
	logic signed [66:0] p2_s11;
	logic signed [67:0] sum_s12;
	logic [33:0]        dm_s13, dm_s14;
	logic               dn_s13, dn_s14;
	logic [60:0]        unu_s14, unv_s14;
	logic [NUM_W-1:0]   nu_s15, nv_s15;
	logic [DEN_W-1:0]   den_s15;
	side3_t             sd_s15;
	logic [66:0]        sm;
	logic [67:0]        smr;

	always_comb begin
		alpha = (blend_ratio_q > Q30_ONE) ? Q30_ONE : blend_ratio_q;
		sm    = sum_s12[67] ? 67'(-sum_s12) : sum_s12[66:0];
		smr   = 68'(sm) + 68'(1 << 29);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s11  <= sd2.t;
			p1_s11 <= alpha * d2;
			p2_s11 <= $signed({1'b0, Q30_ONE - alpha}) * sd2.zsp;

			t_s12   <= t_s11;
			sum_s12 <= $signed({5'b0, p1_s11}) + 68'(p2_s11);

			t_s13    <= t_s12;
			dm_s13   <= smr[63:30];
			dn_s13   <= sum_s12[67];

			t_s14    <= '{ok: t_s13.ok && (dm_s13 != '0), px_neg: t_s13.px_neg,
				py_neg: t_s13.py_neg, mx: t_s13.mx, my: t_s13.my};
			dm_s14   <= dm_s13;
			dn_s14   <= dn_s13;
			unu_s14  <= focal_x_q * t_s13.mx;
			unv_s14  <= focal_y_q * t_s13.my;

			// rounded quotient (2n + d) / 2d
			nu_s15       <= {unu_s14, 1'b0} + NUM_W'(dm_s14);
			nv_s15       <= {unv_s14, 1'b0} + NUM_W'(dm_s14);
			den_s15      <= {dm_s14, 1'b0};
			sd_s15.ok    <= t_s14.ok;
			sd_s15.u_neg <= t_s14.px_neg ^ dn_s14;
			sd_s15.v_neg <= t_s14.py_neg ^ dn_s14;
		end
	end

	logic [QB:0] qu, qv;
	side3_t      sd3;

	dsp_divide #(.QB(QB), .side_t(side3_t)) u_div (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s15), .num_u(nu_s15), .num_v(nv_s15), .den(den_s15),
		.in_side(sd_s15),
		.out_valid(div_valid), .quo_u(qu), .quo_v(qv), .out_side(sd3)
	);

	function automatic logic [W-1:0] to_pixel(
		input logic [QB:0]        q,
		input logic               neg,
		input logic signed [31:0] c
	);
		logic signed [FW-1:0] sv;
		logic [W-1:0]         r;
		sv = $signed({2'b00, q[QB-1:0]});
		if (neg) sv = -sv;
		sv = sv + FW'(c);
		if (q[QB]) r = neg ? SAT_LO[W-1:0] : SAT_HI[W-1:0];
		else if (sv > SAT_HI) r = SAT_HI[W-1:0];
		else if (sv < SAT_LO) r = SAT_LO[W-1:0];
		else r = sv[W-1:0];
		return r;
	endfunction

	logic [W-1:0] pu_q, pv_q;
	logic         ok_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_q <= sd3.ok;
			pu_q <= sd3.ok ? to_pixel(qu, sd3.u_neg, center_x_q) : '0;
			pv_q <= sd3.ok ? to_pixel(qv, sd3.v_neg, center_y_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			v_s10       <= 1'b0;
			v_s11       <= 1'b0;
			v_s12       <= 1'b0;
			v_s13       <= 1'b0;
			v_s14       <= 1'b0;
			v_s15       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= point_in.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= sq1_valid;
			v_s7        <= v_s6;
			v_s8        <= v_s7;
			v_s9        <= v_s8;
			v_s10       <= v_s9;
			v_s11       <= sq2_valid;
			v_s12       <= v_s11;
			v_s13       <= v_s12;
			v_s14       <= v_s13;
			v_s15       <= v_s14;
			out_valid_q <= div_valid;
		end
	end

	assign pixel_out.valid     = out_valid_q;
	assign pixel_out.pixel_u   = pu_q;
	assign pixel_out.pixel_v   = pv_q;
	assign pixel_out.valid_res = ok_q;
endmodule
